// ===== rtl/sorted_key_list_macros.svh =====
// Assertion macros used by the sorted key list top module.
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SKL_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_list: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SKL_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_list: next-cycle check failed");

`endif

// ===== rtl/skl_pkg.sv =====
// Types and constants of the sorted key list.
package skl_pkg;

  localparam int CMD_W       = 2;
  localparam int HANDLE_W    = 16;
  localparam int KEY_W       = 32;
  localparam int OIDX_W      = 16;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int WHERE_W     = 4;
  localparam int CAP_W       = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and its per-entry compares
    logic commit;   // update the list and load the result register
  } skl_ctl_t;

endpackage

// ===== rtl/skl_ctrl.sv =====
// Controller of the sorted key list: request sequencing and result handshake.
module skl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output skl_pkg::skl_ctl_t ctl
);
  import skl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  // Take a request in idle; finish it once the result register is free
  always_comb begin
    s_tready    = (state == S_IDLE);
    ctl.capture = (state == S_IDLE) && s_tvalid;
    ctl.commit  = (state == S_EXEC) && (!m_tvalid || m_tready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    if (ctl.commit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== rtl/skl_datapath.sv =====
// Datapath of the sorted key list: entry cells, compares, count and result register.
module skl_datapath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [skl_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                              cfg_valid,
  input  logic [skl_pkg::CAP_W-1:0]         cfg_data,
  input  skl_pkg::skl_ctl_t                 ctl,
  output logic [skl_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import skl_pkg::*;

  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int WIDE_W = CNT_W + COUNT_W;
  localparam int PAD_W  = OUT_TDATA_W - (STATUS_W + COUNT_W + WHERE_W + HANDLE_W + KEY_W
                          + OIDX_W);

  // Entry cells
  logic [HANDLE_W-1:0]     hnd [LIST_DEPTH];
  logic signed [KEY_W-1:0] key [LIST_DEPTH];
  logic [OIDX_W-1:0]       oix [LIST_DEPTH];

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;

  // Request fields
  cmd_t                    in_cmd;
  logic [HANDLE_W-1:0]     in_handle;
  logic signed [KEY_W-1:0] in_key;
  logic [OIDX_W-1:0]       in_oix;
  logic [POS_W-1:0]        in_pos;

  cmd_t                    req_cmd;
  logic [HANDLE_W-1:0]     req_handle;
  logic signed [KEY_W-1:0] req_key;
  logic [OIDX_W-1:0]       req_oix;
  logic [POS_W-1:0]        req_pos;
  logic [LIST_DEPTH-1:0]   gt;
  logic [LIST_DEPTH-1:0]   match;
  logic [LIST_DEPTH-1:0]   gt_in;
  logic [LIST_DEPTH-1:0]   match_in;

  always_comb begin
    in_cmd    = cmd_t'(s_tdata[1:0]);
    in_handle = s_tdata[17:2];
    in_key    = s_tdata[49:18];
    in_oix    = s_tdata[65:50];
    in_pos    = s_tdata[69:66];
  end

  // Compare the incoming key and handle against every held entry
  always_comb begin
    for (int j = 0; j < LIST_DEPTH; j++) begin
      gt_in[j]    = (CNT_W'(j) < count) && (in_key > key[j]);
      match_in[j] = (CNT_W'(j) < count) && (in_handle == hnd[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd    <= in_cmd;
      req_handle <= in_handle;
      req_key    <= in_key;
      req_oix    <= in_oix;
      req_pos    <= in_pos;
      gt         <= gt_in;
      match      <= match_in;
    end
  end

  // Prefix OR of the handle matches: seen[j] is set from the first match on
  logic [LIST_DEPTH-1:0] pre [IDX_W+1];
  logic [LIST_DEPTH-1:0] seen;
  logic [LIST_DEPTH-1:0] take;
  logic [LIST_DEPTH-1:0] first;

  assign pre[0] = match;
  for (genvar lv = 0; lv < IDX_W; lv++) begin : g_prefix
    for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_bit
      if (j >= (1 << lv)) begin : g_or
        assign pre[lv+1][j] = pre[lv][j] | pre[lv][j - (1 << lv)];
      end else begin : g_pass
        assign pre[lv+1][j] = pre[lv][j];
      end
    end
  end
  assign seen = pre[IDX_W];

  // Mark the insert slot and the first matching entry
  for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_mark
    if (j == 0) begin : g_low
      assign take[j]  = !gt[j];
      assign first[j] = match[j];
    end else begin : g_up
      assign take[j]  = !gt[j] && gt[j-1];
      assign first[j] = match[j] && !seen[j-1];
    end
  end

  // Encode slot positions and select the read entry
  logic [IDX_W-1:0]        ins_idx;
  logic [IDX_W-1:0]        rem_idx;
  logic [HANDLE_W-1:0]     rd_hnd;
  logic signed [KEY_W-1:0] rd_key;
  logic [OIDX_W-1:0]       rd_oix;

  always_comb begin
    ins_idx = '0;
    rem_idx = '0;
    rd_hnd  = '0;
    rd_key  = '0;
    rd_oix  = '0;
    for (int j = 0; j < LIST_DEPTH; j++) begin
      if (take[j]) ins_idx = ins_idx | IDX_W'(j);
      if (first[j]) rem_idx = rem_idx | IDX_W'(j);
      if (32'(req_pos) == j) begin
        rd_hnd = hnd[j];
        rd_key = key[j];
        rd_oix = oix[j];
      end
    end
  end

  // Decide the outcome of the request
  logic [WIDE_W-1:0] cap_w;
  logic [WIDE_W-1:0] eff_cap;
  logic              full;
  logic              found;
  logic              pos_ok;
  logic              do_ins;
  logic              do_rem;
  status_t           res_status;
  logic [WIDE_W-1:0] res_where;
  logic [CNT_W-1:0]  count_next;
  logic [WIDE_W-1:0] count_w;
  logic [HANDLE_W-1:0]     res_hnd;
  logic signed [KEY_W-1:0] res_key;
  logic [OIDX_W-1:0]       res_oix;

  always_comb begin
    cap_w      = WIDE_W'(capacity);
    eff_cap    = (cap_w < WIDE_W'(LIST_DEPTH)) ? cap_w : WIDE_W'(LIST_DEPTH);
    full       = WIDE_W'(count) >= eff_cap;
    found      = seen[LIST_DEPTH-1];
    pos_ok     = WIDE_W'(req_pos) < WIDE_W'(count);
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    res_status = ST_OK;
    res_where  = '0;
    count_next = count;
    res_hnd    = '0;
    res_key    = '0;
    res_oix    = '0;
    unique case (req_cmd)
      CMD_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          res_where  = WIDE_W'(ins_idx);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          do_rem     = 1'b1;
          res_where  = WIDE_W'(rem_idx);
          count_next = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          res_status = ST_BAD_POS;
        end else begin
          res_where = WIDE_W'(req_pos);
          res_hnd   = rd_hnd;
          res_key   = rd_key;
          res_oix   = rd_oix;
        end
      end
      CMD_NONE: begin
        res_status = ST_OK;
      end
      default: res_status = ST_OK;
    endcase
    count_w = WIDE_W'(count_next);
  end

  // Update each cell from the request, a neighbor or itself
  for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.commit) begin
        if (do_ins && !gt[j]) begin
          if (take[j]) begin
            hnd[j] <= req_handle;
            key[j] <= req_key;
            oix[j] <= req_oix;
          end else begin
            hnd[j] <= hnd[(j > 0) ? j - 1 : 0];
            key[j] <= key[(j > 0) ? j - 1 : 0];
            oix[j] <= oix[(j > 0) ? j - 1 : 0];
          end
        end else if (do_rem && seen[j] && (j < LIST_DEPTH - 1)) begin
          hnd[j] <= hnd[(j < LIST_DEPTH - 1) ? j + 1 : j];
          key[j] <= key[(j < LIST_DEPTH - 1) ? j + 1 : j];
          oix[j] <= oix[(j < LIST_DEPTH - 1) ? j + 1 : j];
        end
      end
    end
  end

  // Hold the capacity register and the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;
      if (ctl.commit) count <= count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      m_tdata <= {{PAD_W{1'b0}}, res_oix, res_key, res_hnd, res_where[WHERE_W-1:0],
                  count_w[COUNT_W-1:0], res_status};
    end
  end

endmodule

// ===== rtl/sorted_key_list.sv =====
// Sorted key list: a request is accepted in idle and latched with its compares; the
// controller then commits it to the entry cells and result register and takes no new
// request until that commit. Stalls on the result side hold the commit until the
// result register frees.
// Synchronous active-high reset empties the list and sets capacity to 16;
// entry contents are not cleared, since positions beyond the count are never read.
module sorted_key_list #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [1:0] cmd, [17:2] handle, [49:18] sort_key, [65:50] orig_index, [69:66] position
  input  logic [skl_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] status, [6:2] new_count, [10:7] where_placed, [26:11] out_handle,
  // [58:27] out_key, [74:59] out_orig_index
  output logic [skl_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [skl_pkg::CAP_W-1:0]        cfg_data
);
  import skl_pkg::*;

  skl_ctl_t ctl;

  assign cfg_ready = 1'b1;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  skl_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .m_tdata   (m_tdata)
  );

  `include "sorted_key_list_macros.svh"

  // A request in flight blocks the next one
  `SKL_CHECK_NEXT(a_busy_after_take, ctl.capture, !s_tready)
  // A commit always presents a result
  `SKL_CHECK_NEXT(a_result_after_commit, ctl.commit, m_tvalid)
  // Never overwrite a result the sink has not taken
  `SKL_CHECK_NOW(a_no_overwrite, m_tvalid && !m_tready, !ctl.commit)

endmodule
